[src/sise_pkg.sv]
package sise_pkg;

    typedef enum logic [1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_TOGGLE = 2'd2,
        FUNC_LOOKUP = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_RANGE = 2'd2,
        STATUS_RSVD  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRE,
        ST_MID,
        ST_POST,
        ST_LOOK,
        ST_DONE
    } t_state;

endpackage

[src/sise_ifs.sv]
interface sise_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [31:0] start_point;
    logic [31:0] span_length;

    modport source (output valid, func, start_point, span_length, input ready);
    modport sink   (input valid, func, start_point, span_length, output ready);
endinterface

interface sise_rsp_if #(
    parameter int CNT_W      = 7,
    parameter int POINT_BITS = 32
);
    logic                  valid;
    logic                  ready;
    logic [1:0]            status;
    logic                  inside_res;
    logic [CNT_W-1:0]      interval_index;
    logic [POINT_BITS-1:0] found_begin;
    logic [POINT_BITS-1:0] found_end;
    logic [CNT_W-1:0]      intervals_held;

    modport source (output valid, status, inside_res, interval_index, found_begin,
                    found_end, intervals_held, input ready);
    modport sink   (input valid, status, inside_res, interval_index, found_begin,
                    found_end, intervals_held, output ready);
endinterface

[src/sorted_interval_set_engine_unit.sv]
// Sorted interval set engine. Holds up to MAX_INTERVALS disjoint, non-touching half-open
// intervals in two ping-pong memories (one word per interval, {end, begin}). Add, remove
// and toggle walk the boundaries of the current bank one per cycle, drop or insert the
// request's start and end boundaries, and write the rebuilt table into the other bank;
// the banks swap only on success, so a full table is left unchanged. A range error or
// zero-length add, remove or toggle skips the walk and goes straight to the response,
// which is held back in ST_DONE while the previous response still waits. The engine
// returns to idle and raises ready as the response is registered. No clearing pass
// follows reset. A new request is taken while the previous response still waits.
module sorted_interval_set_engine_unit #(
    parameter int MAX_INTERVALS = 64,
    parameter int POINT_BITS    = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sise_req_if.sink   i_req,
    sise_rsp_if.source o_rsp
);

    localparam int CNT_W = $clog2(MAX_INTERVALS + 1);
    localparam int AW    = $clog2(MAX_INTERVALS);
    localparam int NB_W  = $clog2(2 * MAX_INTERVALS + 3);
    localparam int CW    = ((POINT_BITS > 32) ? POINT_BITS : 32) + 1;
    localparam int DW    = 2 * POINT_BITS;

    sise_pkg::t_state        r_state, n_state;
    sise_pkg::t_func         r_func, n_func;
    logic [CW-1:0]           r_s, n_s, r_e, n_e;
    logic [NB_W-1:0]         r_j, n_j, r_nb, n_nb;
    logic [POINT_BITS-1:0]   r_half, n_half;
    logic [CNT_W-1:0]        r_count, n_count;
    logic                    r_bank, n_bank;
    sise_pkg::t_status       r_res_status, n_res_status;
    logic                    r_res_inside, n_res_inside;
    logic [CNT_W-1:0]        r_res_idx, n_res_idx;
    logic [POINT_BITS-1:0]   r_res_fb, n_res_fb, r_res_fe, n_res_fe;
    logic                    r_ovalid, n_ovalid;
    sise_pkg::t_status       r_o_status, n_o_status;
    logic                    r_o_inside, n_o_inside;
    logic [CNT_W-1:0]        r_o_idx, n_o_idx, r_o_held, n_o_held;
    logic [POINT_BITS-1:0]   r_o_fb, n_o_fb, r_o_fe, n_o_fe;

    logic [DW-1:0]           rd0, rd1, rd;
    logic [AW-1:0]           raddr, waddr;
    logic                    we0, we1, we;
    logic [DW-1:0]           wdata;

    logic                    req_acc, exh, p;
    logic [POINT_BITS-1:0]   cur;
    logic [CW-1:0]           cur_x, in_e;
    logic                    in_ovf, hit_s, hit_e;
    logic                    emit;
    logic [POINT_BITS-1:0]   ev;
    logic [NB_W-1:0]         nint;

    assign req_acc = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == sise_pkg::ST_IDLE);

    assign rd    = r_bank ? rd1 : rd0;
    assign cur   = r_j[0] ? rd[DW-1:POINT_BITS] : rd[POINT_BITS-1:0];
    assign cur_x = CW'(cur);
    assign exh   = (r_j >= NB_W'({r_count, 1'b0}));
    assign p     = r_j[0];
    assign hit_s = !exh && (cur_x == r_s);
    assign hit_e = !exh && (cur_x == r_e);
    assign in_e  = CW'(i_req.start_point) + CW'(i_req.span_length);
    assign in_ovf = (in_e >> POINT_BITS) != '0;
    assign nint  = r_nb >> 1;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sise_pkg::ST_IDLE: begin
                if (req_acc) begin
                    if (i_req.func == sise_pkg::FUNC_LOOKUP) begin
                        n_state = sise_pkg::ST_LOOK;
                    end else if (in_ovf || i_req.span_length == '0) begin
                        n_state = sise_pkg::ST_DONE;
                    end else begin
                        n_state = sise_pkg::ST_PRE;
                    end
                end
            end
            sise_pkg::ST_PRE: begin
                if (exh || cur_x >= r_s) n_state = sise_pkg::ST_MID;
            end
            sise_pkg::ST_MID: begin
                if (r_func == sise_pkg::FUNC_TOGGLE) begin
                    if (exh || cur_x >= r_e) n_state = sise_pkg::ST_POST;
                end else if (exh || cur_x > r_e) begin
                    n_state = sise_pkg::ST_POST;
                end
            end
            sise_pkg::ST_POST: begin
                if (exh) n_state = sise_pkg::ST_DONE;
            end
            sise_pkg::ST_LOOK: begin
                if (exh || cur_x > r_s) n_state = sise_pkg::ST_DONE;
            end
            sise_pkg::ST_DONE: begin
                if (!r_ovalid || o_rsp.ready) n_state = sise_pkg::ST_IDLE;
            end
            default: n_state = sise_pkg::ST_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        n_func       = r_func;
        n_s          = r_s;
        n_e          = r_e;
        n_j          = r_j;
        n_nb         = r_nb;
        n_half       = r_half;
        n_count      = r_count;
        n_bank       = r_bank;
        n_res_status = r_res_status;
        n_res_inside = r_res_inside;
        n_res_idx    = r_res_idx;
        n_res_fb     = r_res_fb;
        n_res_fe     = r_res_fe;
        n_ovalid     = r_ovalid && !o_rsp.ready;
        n_o_status   = r_o_status;
        n_o_inside   = r_o_inside;
        n_o_idx      = r_o_idx;
        n_o_held     = r_o_held;
        n_o_fb       = r_o_fb;
        n_o_fe       = r_o_fe;
        emit         = 1'b0;
        ev           = cur;
        we           = 1'b0;

        unique case (r_state)
            sise_pkg::ST_IDLE: begin
                n_j  = '0;
                n_nb = '0;
                if (req_acc) begin
                    n_func       = sise_pkg::t_func'(i_req.func);
                    n_s          = CW'(i_req.start_point);
                    n_e          = in_e;
                    n_res_status = in_ovf && (i_req.func != sise_pkg::FUNC_LOOKUP) ?
                                   sise_pkg::STATUS_RANGE : sise_pkg::STATUS_OK;
                    n_res_inside = 1'b0;
                    n_res_idx    = '0;
                    n_res_fb     = '0;
                    n_res_fe     = '0;
                end
            end
            sise_pkg::ST_PRE: begin
                if (!exh && cur_x < r_s) begin
                    emit = 1'b1;
                    n_j  = r_j + 1'b1;
                end else begin
                    ev = r_s[POINT_BITS-1:0];
                    unique case (r_func)
                        sise_pkg::FUNC_ADD:    emit = !p;
                        sise_pkg::FUNC_REMOVE: emit = p;
                        default: begin
                            emit = !hit_s;
                            if (hit_s) n_j = r_j + 1'b1;
                        end
                    endcase
                end
            end
            sise_pkg::ST_MID: begin
                if (r_func == sise_pkg::FUNC_TOGGLE) begin
                    if (!exh && cur_x < r_e) begin
                        emit = 1'b1;
                        n_j  = r_j + 1'b1;
                    end else begin
                        ev   = r_e[POINT_BITS-1:0];
                        emit = !hit_e;
                        if (hit_e) n_j = r_j + 1'b1;
                    end
                end else if (!exh && cur_x <= r_e) begin
                    n_j = r_j + 1'b1;   // covered boundary dropped
                end else begin
                    ev   = r_e[POINT_BITS-1:0];
                    emit = (r_func == sise_pkg::FUNC_ADD) ? !p : p;
                end
            end
            sise_pkg::ST_POST: begin
                if (!exh) begin
                    emit = 1'b1;
                    n_j  = r_j + 1'b1;
                end else if (nint > NB_W'(MAX_INTERVALS)) begin
                    n_res_status = sise_pkg::STATUS_FULL;
                end else begin
                    n_bank  = !r_bank;
                    n_count = nint[CNT_W-1:0];
                end
            end
            sise_pkg::ST_LOOK: begin
                if (!exh && cur_x <= r_s) begin
                    n_j = r_j + 1'b1;
                end else if (exh) begin
                    n_res_idx = r_count;
                end else begin
                    n_res_inside = r_j[0];
                    n_res_idx    = CNT_W'(r_j >> 1);
                    n_res_fb     = rd[POINT_BITS-1:0];
                    n_res_fe     = rd[DW-1:POINT_BITS];
                end
            end
            sise_pkg::ST_DONE: begin
                if (!r_ovalid || o_rsp.ready) begin
                    n_ovalid   = 1'b1;
                    n_o_status = r_res_status;
                    n_o_inside = r_res_inside;
                    n_o_idx    = r_res_idx;
                    n_o_fb     = r_res_fb;
                    n_o_fe     = r_res_fe;
                    n_o_held   = r_count;
                end
            end
            default: ;
        endcase

        // pair emitted boundaries into intervals
        if (emit) begin
            n_nb = r_nb + 1'b1;
            if (!r_nb[0]) begin
                n_half = ev;
            end else begin
                we = (nint < NB_W'(MAX_INTERVALS));
            end
        end
    end

    assign raddr = AW'(n_j >> 1);
    assign waddr = AW'(nint);
    assign wdata = {ev, r_half};
    assign we0   = we && r_bank;
    assign we1   = we && !r_bank;

    sise_ram #(.WIDTH(DW), .DEPTH(MAX_INTERVALS)) u_bank0 (
        .i_clk  (i_clk),
        .i_we   (we0),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rd0)
    );

    sise_ram #(.WIDTH(DW), .DEPTH(MAX_INTERVALS)) u_bank1 (
        .i_clk  (i_clk),
        .i_we   (we1),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rd1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sise_pkg::ST_IDLE;
            r_count  <= '0;
            r_bank   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_bank   <= n_bank;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func       <= n_func;
        r_s          <= n_s;
        r_e          <= n_e;
        r_j          <= n_j;
        r_nb         <= n_nb;
        r_half       <= n_half;
        r_res_status <= n_res_status;
        r_res_inside <= n_res_inside;
        r_res_idx    <= n_res_idx;
        r_res_fb     <= n_res_fb;
        r_res_fe     <= n_res_fe;
        r_o_status   <= n_o_status;
        r_o_inside   <= n_o_inside;
        r_o_idx      <= n_o_idx;
        r_o_held     <= n_o_held;
        r_o_fb       <= n_o_fb;
        r_o_fe       <= n_o_fe;
    end

    assign o_rsp.valid          = r_ovalid;
    assign o_rsp.status         = r_o_status;
    assign o_rsp.inside_res     = r_o_inside;
    assign o_rsp.interval_index = r_o_idx;
    assign o_rsp.found_begin    = r_o_fb;
    assign o_rsp.found_end      = r_o_fe;
    assign o_rsp.intervals_held = r_o_held;

endmodule

[src/sise_ram.sv]
module sise_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[tb/tb_sorted_interval_set_engine_unit.sv]
module tb_sorted_interval_set_engine_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_IV = 64;
    localparam longint unsigned PT_MAX = 64'hFFFF_FFFF;

    typedef struct packed {
        sise_pkg::t_func func;
        logic [31:0]     start_point;
        logic [31:0]     span_length;
    } t_req;

    typedef struct packed {
        sise_pkg::t_status status;
        logic              inside_res;
        logic [6:0]        interval_index;
        logic [31:0]       found_begin;
        logic [31:0]       found_end;
        logic [6:0]        intervals_held;
    } t_rsp;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    sise_req_if req_if ();
    sise_rsp_if #(.CNT_W(7), .POINT_BITS(32)) rsp_if ();

    sorted_interval_set_engine_unit #(.MAX_INTERVALS(MAX_IV), .POINT_BITS(32)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if.sink),
        .o_rsp  (rsp_if.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow of the interval table
    longint unsigned iv_lo[$];
    longint unsigned iv_hi[$];

    t_req pending_reqs[$];
    t_rsp expected_rsps[$];

    int send_idle_pct = 22;
    int recv_idle_pct = 80;
    bit recv_hold = 1'b0;
    bit send_pause = 1'b0;
    int mismatches = 0;
    int rsp_count = 0;
    int full_seen = 0;
    int range_seen = 0;
    int inside_seen = 0;
    int max_held = 0;

    // apply one request to the shadow table and return the expected response
    function automatic t_rsp predict_interval_op(t_req r);
        t_rsp o;
        longint unsigned s, e, lo, hi, a, b;
        longint unsigned bnd[$];
        longint unsigned nb[$];
        int n, i;
        bit hit;
        o = '0;
        s = r.start_point;
        n = iv_lo.size();
        if (r.func == sise_pkg::FUNC_LOOKUP) begin
            o.interval_index = 7'(n);
            for (i = 0; i < n; i++) begin
                if (s < iv_lo[i]) begin
                    o.interval_index = 7'(i);
                    break;
                end
                if (s < iv_hi[i]) begin
                    o.interval_index = 7'(i);
                    o.inside_res = 1'b1;
                    break;
                end
            end
            if (o.interval_index < n) begin
                o.found_begin = 32'(iv_lo[o.interval_index]);
                o.found_end = 32'(iv_hi[o.interval_index]);
            end
        end else begin
            e = s + longint'(r.span_length);
            if (e > PT_MAX) begin
                o.status = sise_pkg::STATUS_RANGE;
            end else if (r.span_length != 0) begin
                if (r.func == sise_pkg::FUNC_ADD) begin
                    a = s;
                    b = e;
                    i = 0;
                    while (i < n && iv_hi[i] < s) begin
                        bnd.push_back(iv_lo[i]); bnd.push_back(iv_hi[i]); i++;
                    end
                    while (i < n && iv_lo[i] <= e) begin
                        if (iv_lo[i] < a) a = iv_lo[i];
                        if (iv_hi[i] > b) b = iv_hi[i];
                        i++;
                    end
                    bnd.push_back(a); bnd.push_back(b);
                    while (i < n) begin
                        bnd.push_back(iv_lo[i]); bnd.push_back(iv_hi[i]); i++;
                    end
                end else if (r.func == sise_pkg::FUNC_REMOVE) begin
                    for (i = 0; i < n; i++) begin
                        lo = (iv_hi[i] < s) ? iv_hi[i] : s;
                        hi = (iv_lo[i] > e) ? iv_lo[i] : e;
                        if (iv_lo[i] < lo) begin
                            bnd.push_back(iv_lo[i]); bnd.push_back(lo);
                        end
                        if (hi < iv_hi[i]) begin
                            bnd.push_back(hi); bnd.push_back(iv_hi[i]);
                        end
                    end
                end else begin
                    // toggle: XOR both boundaries into the sorted boundary list
                    for (i = 0; i < n; i++) begin
                        nb.push_back(iv_lo[i]); nb.push_back(iv_hi[i]);
                    end
                    foreach (nb[k]) bnd.push_back(nb[k]);
                    for (int pass = 0; pass < 2; pass++) begin
                        a = pass ? e : s;
                        nb = {};
                        hit = 1'b0;
                        foreach (bnd[k]) begin
                            if (!hit && bnd[k] >= a) begin
                                hit = 1'b1;
                                if (bnd[k] != a) begin
                                    nb.push_back(a); nb.push_back(bnd[k]);
                                end
                            end else begin
                                nb.push_back(bnd[k]);
                            end
                        end
                        if (!hit) nb.push_back(a);
                        bnd = nb;
                    end
                end
                if (bnd.size() / 2 > MAX_IV) begin
                    o.status = sise_pkg::STATUS_FULL;
                end else begin
                    iv_lo = {};
                    iv_hi = {};
                    for (i = 0; i < bnd.size() / 2; i++) begin
                        iv_lo.push_back(bnd[2*i]);
                        iv_hi.push_back(bnd[2*i+1]);
                    end
                end
            end
        end
        o.intervals_held = 7'(iv_lo.size());
        return o;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_if.ready) begin
            if (req_if.valid) expected_rsps.push_back(predict_interval_op(pending_reqs.pop_front()));
            if (pending_reqs.size() > 0 && !send_pause
                    && $urandom_range(99) >= send_idle_pct) begin
                req_if.valid <= 1'b1;
                req_if.func <= pending_reqs[0].func;
                req_if.start_point <= pending_reqs[0].start_point;
                req_if.span_length <= pending_reqs[0].span_length;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    initial begin
        req_if.valid = 1'b0;
        req_if.func = sise_pkg::FUNC_ADD;
        req_if.start_point = '0;
        req_if.span_length = '0;
        rsp_if.ready = 1'b0;
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                t_rsp got, want;
                got = {sise_pkg::t_status'(rsp_if.status), rsp_if.inside_res,
                       rsp_if.interval_index, rsp_if.found_begin, rsp_if.found_end,
                       rsp_if.intervals_held};
                rsp_count++;
                if (expected_rsps.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected response %p", got);
                end else begin
                    want = expected_rsps.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("response %0d mismatch: expected %p, got %p",
                                     rsp_count, want, got);
                    end
                    if (got.status == sise_pkg::STATUS_FULL) full_seen++;
                    if (got.status == sise_pkg::STATUS_RANGE) range_seen++;
                    if (got.inside_res) inside_seen++;
                    if (got.intervals_held > max_held) max_held = got.intervals_held;
                end
            end
            rsp_if.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic t_req mk_req(sise_pkg::t_func f, longint unsigned s,
                                    longint unsigned l);
        t_req r;
        r.func = f;
        r.start_point = 32'(s);
        r.span_length = 32'(l);
        return r;
    endfunction

    // well-formed random request over a window chosen to keep the table busy
    function automatic t_req rand_req(int mode);
        t_req r;
        int unsigned f;
        f = $urandom_range(99);
        r.func = (f < 35) ? sise_pkg::FUNC_ADD : (f < 55) ? sise_pkg::FUNC_REMOVE
                 : (f < 75) ? sise_pkg::FUNC_TOGGLE : sise_pkg::FUNC_LOOKUP;
        case (mode)
            0: begin
                r.start_point = $urandom_range(400);
                r.span_length = $urandom_range(6);
            end
            1: begin
                r.start_point = $urandom;
                r.span_length = ($urandom_range(3) == 0) ? $urandom : $urandom_range(1000);
            end
            default: begin
                r.start_point = 32'hFFFF_FFFF - $urandom_range(300);
                r.span_length = $urandom_range(320);
            end
        endcase
        return r;
    endfunction

    task automatic drain_expected();
        while (pending_reqs.size() > 0 || req_if.valid || expected_rsps.size() > 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic run_random(int cnt);
        int m;
        for (int k = 0; k < cnt; k++) begin
            m = $urandom_range(9);
            pending_reqs.push_back(rand_req(m < 7 ? 0 : m < 9 ? 1 : 2));
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty lookups, zero length, range overflow, merge, split, toggle
        pending_reqs.push_back(mk_req(sise_pkg::FUNC_LOOKUP, 0, 0));
        pending_reqs.push_back(mk_req(sise_pkg::FUNC_LOOKUP, PT_MAX, PT_MAX));
        pending_reqs.push_back(mk_req(sise_pkg::FUNC_ADD, 10, 0));
        pending_reqs.push_back(mk_req(sise_pkg::FUNC_ADD, PT_MAX, 1));
        pending_reqs.push_back(mk_req(sise_pkg::FUNC_REMOVE, PT_MAX, 0));
        pending_reqs.push_back(mk_req(sise_pkg::FUNC_TOGGLE, 1, PT_MAX));
        pending_reqs.push_back(mk_req(sise_pkg::FUNC_ADD, 0, PT_MAX));
        pending_reqs.push_back(mk_req(sise_pkg::FUNC_LOOKUP, PT_MAX - 1, 0));
        pending_reqs.push_back(mk_req(sise_pkg::FUNC_LOOKUP, PT_MAX, 0));
        pending_reqs.push_back(mk_req(sise_pkg::FUNC_REMOVE, 100, 50));
        pending_reqs.push_back(mk_req(sise_pkg::FUNC_LOOKUP, 120, 0));
        pending_reqs.push_back(mk_req(sise_pkg::FUNC_LOOKUP, 150, 0));
        pending_reqs.push_back(mk_req(sise_pkg::FUNC_ADD, 150, 1));
        pending_reqs.push_back(mk_req(sise_pkg::FUNC_TOGGLE, 50, 200));
        pending_reqs.push_back(mk_req(sise_pkg::FUNC_REMOVE, 0, PT_MAX));
        pending_reqs.push_back(mk_req(sise_pkg::FUNC_ADD, 5, 5));
        pending_reqs.push_back(mk_req(sise_pkg::FUNC_ADD, 10, 5));
        pending_reqs.push_back(mk_req(sise_pkg::FUNC_TOGGLE, 5, 10));
        pending_reqs.push_back(mk_req(sise_pkg::FUNC_TOGGLE, 5, 10));
        pending_reqs.push_back(mk_req(sise_pkg::FUNC_LOOKUP, 15, 0));
        pending_reqs.push_back(mk_req(sise_pkg::FUNC_LOOKUP, 4, 0));
        // fill the table to capacity, then overflow it
        for (int k = 0; k < MAX_IV; k++)
            pending_reqs.push_back(mk_req(sise_pkg::FUNC_ADD, 1000 + 4 * k, 2));
        pending_reqs.push_back(mk_req(sise_pkg::FUNC_ADD, 2000, 1));
        pending_reqs.push_back(mk_req(sise_pkg::FUNC_REMOVE, 1001, 1));
        pending_reqs.push_back(mk_req(sise_pkg::FUNC_TOGGLE, 1003, 1));
        pending_reqs.push_back(mk_req(sise_pkg::FUNC_LOOKUP, 1001, 0));
        drain_expected();

        // long receiver hold-off while requests keep coming
        run_random(40);
        recv_hold = 1'b1;
        repeat (3000) @(posedge i_clk);
        recv_hold = 1'b0;
        drain_expected();

        run_random(330);
        drain_expected();
        send_idle_pct = 80;
        recv_idle_pct = 22;
        run_random(300);
        drain_expected();
        // sender pauses until all responses are back
        send_pause = 1'b1;
        run_random(20);
        repeat (200) @(posedge i_clk);
        wait (expected_rsps.size() == 0);
        send_pause = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(310);
        drain_expected();

        $display("covered %0d responses: %0d table-full, %0d range errors, %0d hits, peak %0d",
                 rsp_count, full_seen, range_seen, inside_seen, max_held);
        if (mismatches == 0 && expected_rsps.size() == 0) begin
            $display("sorted_interval_set_engine_unit regression: pass");
        end else begin
            $display("%0d mismatches, %0d responses missing", mismatches,
                     expected_rsps.size());
            $display("sorted_interval_set_engine_unit regression: fail");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("timeout");
        $display("sorted_interval_set_engine_unit regression: fail");
        $finish;
    end
endmodule

[sorted_interval_set_engine_unit.f]
src/sise_pkg.sv
src/sise_ifs.sv
src/sise_ram.sv
src/sorted_interval_set_engine_unit.sv
tb/tb_sorted_interval_set_engine_unit.sv
